>>> sv/vbm_pkg.sv
package vbm_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_INPUT_KIND  = 3'd0;
  localparam logic [2:0] REG_OUTPUT_MODE = 3'd1;
  localparam logic [2:0] REG_SPAN_MODE   = 3'd2;
  localparam logic [2:0] REG_SELECT_MAX  = 3'd3;
  localparam logic [2:0] REG_ONESHOT_MS  = 3'd4;
  localparam logic [2:0] REG_DEBOUNCE_MS = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // field codes
  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_POLL      = 1'b1;
  localparam logic KIND_PUSH    = 1'b0;
  localparam logic KIND_TOGGLE  = 1'b1;
  localparam logic MODE_DIRECT  = 1'b0;
  localparam logic MODE_SELECT  = 1'b1;
  localparam logic SPAN_HOLD    = 1'b0;
  localparam logic SPAN_ONESHOT = 1'b1;

  // register reset values
  localparam logic [3:0]  SELECT_MAX_RST  = 4'd2;
  localparam logic [15:0] ONESHOT_MS_RST  = 16'd100;
  localparam logic [9:0]  DEBOUNCE_MS_RST = 10'd20;

  // last_reported value meaning nothing reported yet
  localparam logic [4:0] NONE_REPORTED = 5'd31;

  typedef struct packed {
    logic        input_kind;
    logic        output_mode;
    logic        span_mode;
    logic [3:0]  select_max;
    logic [15:0] oneshot_ms;
    logic [9:0]  debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic        accepted_level;
    logic        pending_change;
    logic        release_armed;
    logic [3:0]  virtual_value;
    logic [31:0] release_deadline;
    logic [31:0] last_sample_time;
    logic [4:0]  last_reported;
  } state_t;

  typedef struct packed {
    logic        operation;
    logic        level;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic       event_valid;
    logic [3:0] event_value;
    logic [3:0] current_value;
  } result_t;

  localparam state_t STATE_RST = '{
    accepted_level:   1'b0,
    pending_change:   1'b0,
    release_armed:    1'b0,
    virtual_value:    4'd0,
    release_deadline: 32'd0,
    last_sample_time: 32'd0,
    last_reported:    NONE_REPORTED
  };

endpackage

>>> sv/virtual_button_mapper_core.sv
// virtual button mapper core
//
// sample channel: sample_valid/sample_stall with operation, level, now_ms.
//   a word is taken on a rising edge with sample_valid high and sample_stall
//   low. operation 0 loads a debounced button sample, operation 1 polls.
// result channel: result_valid/result_stall with event_valid, event_value
//   and current_value; exactly one result word per sample word, in order.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
//   ready. writes are meant for idle periods only. a write to input_kind,
//   output_mode or span_mode returns the mapper state to its reset values.
// path: a taken word waits in the input register and moves into the result
//   register on an edge where the result register is free or being drained.
// throughput: one word per cycle when unstalled; the mapper state is read and
//   rewritten by one pass of compare/add logic between the input and result registers.
// stall: while result_stall holds a full result register, the input
//   register holds its word and sample_stall rises once it is also full.
// reset: rst (synchronous) empties both registers, loads the register
//   defaults and clears the mapper state (nothing reported yet).
module virtual_button_mapper_core (
  input  logic                             clk,
  input  logic                             rst,
  // sample channel
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic                             operation,
  input  logic                             level,
  input  logic [31:0]                      now_ms,
  // result channel
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             event_valid,
  output logic [3:0]                       event_value,
  output logic [3:0]                       current_value,
  // config channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [vbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import vbm_pkg::*;

  cfg_t    cfg;
  logic    state_clear;
  state_t  st;
  state_t  st_next;
  item_t   item;
  result_t res;

  logic    held;          // input register holds a word
  logic    advance;       // result register can take a new word
  logic    accept;

  assign cfg_ready = 1'b1;

  vbm_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg         (cfg),
    .state_clear (state_clear)
  );

  // result register is free or being drained this cycle
  assign advance      = !result_valid || !result_stall;
  assign sample_stall = held && !advance;
  assign accept       = sample_valid && !sample_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept || (held && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.operation <= operation;
      item.level     <= level;
      item.now_ms    <= now_ms;
    end
  end

  vbm_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  // mapper state, updated as the word moves into the result register
  always_ff @(posedge clk) begin
    if (rst || state_clear) begin
      st <= STATE_RST;
    end else if (held && advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (held && advance) begin
      event_valid   <= res.event_valid;
      event_value   <= res.event_value;
      current_value <= res.current_value;
    end
  end

  // a silent poll or a sample never carries an event value
  a_quiet_value : assert property (@(posedge clk) disable iff (rst)
    result_valid && !event_valid |-> event_value == 4'd0)
    else $error("event_value set without event_valid");

  // last_reported is a 4-bit value or the none code
  a_reported_legal : assert property (@(posedge clk) disable iff (rst)
    st.last_reported[4] == 1'b0 || st.last_reported == NONE_REPORTED)
    else $error("last_reported holds an illegal code");

  // a poll that leaves the input register always clears the pending change
  a_poll_clears : assert property (@(posedge clk) disable iff (rst)
    held && advance && item.operation == OP_POLL |=> !st.pending_change)
    else $error("pending change survived a poll");

  // a held word with a stalled result register stays put
  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    held && !advance |=> held && $stable(item))
    else $error("input register lost its word under stall");

endmodule

>>> sv/vbm_cfg_regs.sv
module vbm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vbm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output vbm_pkg::cfg_t                     cfg,
  output logic                              state_clear
);
  import vbm_pkg::*;

  // a mode write restarts the mapper
  assign state_clear = cfg_we &&
    (cfg_index inside {REG_INPUT_KIND, REG_OUTPUT_MODE, REG_SPAN_MODE});

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_kind  <= KIND_PUSH;
      cfg.output_mode <= MODE_DIRECT;
      cfg.span_mode   <= SPAN_HOLD;
      cfg.select_max  <= SELECT_MAX_RST;
      cfg.oneshot_ms  <= ONESHOT_MS_RST;
      cfg.debounce_ms <= DEBOUNCE_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_KIND:  cfg.input_kind  <= cfg_data[0];
        REG_OUTPUT_MODE: cfg.output_mode <= cfg_data[0];
        REG_SPAN_MODE:   cfg.span_mode   <= cfg_data[0];
        REG_SELECT_MAX:  cfg.select_max  <= cfg_data[3:0];
        REG_ONESHOT_MS:  cfg.oneshot_ms  <= cfg_data[15:0];
        REG_DEBOUNCE_MS: cfg.debounce_ms <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/vbm_step.sv
module vbm_step (
  input  vbm_pkg::cfg_t    cfg,
  input  vbm_pkg::state_t  st,
  input  vbm_pkg::item_t   item,
  output vbm_pkg::state_t  st_next,
  output vbm_pkg::result_t res
);
  import vbm_pkg::*;

  logic [31:0] gap;
  logic        debounced;
  logic [4:0]  sel_v;

  assign gap       = item.now_ms - st.last_sample_time;
  assign debounced = gap > {22'd0, cfg.debounce_ms};

  always_comb begin
    st_next           = st;
    res.event_valid   = 1'b0;
    res.event_value   = 4'd0;
    sel_v             = {1'b0, st.virtual_value};
    if (item.operation == OP_SAMPLE) begin
      if (debounced && (item.level != st.accepted_level)) begin
        st_next.accepted_level = item.level;
        if (cfg.output_mode == MODE_DIRECT) begin
          st_next.virtual_value  = {3'd0, item.level} + 4'd1;
          st_next.pending_change = 1'b1;
        end else begin
          if (cfg.input_kind == KIND_PUSH) begin
            if (item.level) begin
              sel_v                  = sel_v + 5'd1;
              st_next.pending_change = 1'b1;
            end
          end else begin
            if (cfg.select_max == SELECT_MAX_RST) begin
              sel_v = {4'd0, item.level} + 5'd1;
            end else begin
              sel_v = sel_v + 5'd1;
            end
            st_next.pending_change = 1'b1;
          end
          // wrap past the top back to one, also on a release
          if (sel_v > {1'b0, cfg.select_max}) begin
            sel_v = 5'd1;
          end
          st_next.virtual_value = sel_v[3:0];
        end
        if (st_next.pending_change && (cfg.span_mode == SPAN_ONESHOT)) begin
          st_next.release_deadline = item.now_ms + {16'd0, cfg.oneshot_ms};
          st_next.release_armed    = 1'b1;
        end
      end
      st_next.last_sample_time = item.now_ms;
    end else begin
      if (st.pending_change) begin
        if (st.last_reported != {1'b0, st.virtual_value}) begin
          res.event_valid       = 1'b1;
          res.event_value       = st.virtual_value;
          st_next.last_reported = {1'b0, st.virtual_value};
        end
        st_next.pending_change = 1'b0;
      end else if (st.release_armed && (cfg.span_mode == SPAN_ONESHOT) &&
                   (st.release_deadline < item.now_ms)) begin
        if (st.last_reported != 5'd0) begin
          res.event_valid       = 1'b1;
          res.event_value       = 4'd0;
          st_next.last_reported = 5'd0;
        end else begin
          st_next.last_reported = NONE_REPORTED;
        end
        st_next.release_armed = 1'b0;
      end
    end
    res.current_value = st_next.virtual_value;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import vbm_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the pipe
  localparam int DRAIN_CYCLES = 8;     // settling margin after the last result
  localparam int MAX_REPORTS  = 10;

  // indexes past the last register, the block must ignore them
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // toggle switch in select mode with this maximum follows the level directly
  localparam logic [3:0] TOGGLE_PAIR_MAX = 4'd2;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  // sample channel
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic        operation    = OP_SAMPLE;
  logic        level        = 1'b0;
  logic [31:0] now_ms       = 32'd0;

  // result channel
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        event_valid;
  logic [3:0]  event_value;
  logic [3:0]  current_value;

  // config channel
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  virtual_button_mapper_core u_top (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .operation     (operation),
    .level         (level),
    .now_ms        (now_ms),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .event_valid   (event_valid),
    .event_value   (event_value),
    .current_value (current_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // mirror of the register file and the mapper state
  cfg_t   cfg_mirror;
  state_t btn;

  // predicted result words, oldest first
  result_t button_out_q[$];

  // idling knobs for the current phase
  int gap_pct   = 0;
  int stall_pct = 0;

  // long hold-off requests, counted out by the receiver process
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // sequence tracking for well-formed random stimulus
  logic [31:0] ms_cursor = 32'd0;
  logic        last_lvl  = 1'b0;

  // bookkeeping
  int words_sent    = 0;
  int words_checked = 0;
  int mismatches    = 0;
  int offer_stalls  = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // mapper prediction
  // ---------------------------------------------------------------------------

  // register write as the block sees it; mode bits wipe the mapper state
  function automatic void apply_reg_write(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_INPUT_KIND: begin
        cfg_mirror.input_kind = data[0];
        btn = STATE_RST;
      end
      REG_OUTPUT_MODE: begin
        cfg_mirror.output_mode = data[0];
        btn = STATE_RST;
      end
      REG_SPAN_MODE: begin
        cfg_mirror.span_mode = data[0];
        btn = STATE_RST;
      end
      REG_SELECT_MAX:  cfg_mirror.select_max  = data[3:0];
      REG_ONESHOT_MS:  cfg_mirror.oneshot_ms  = data[15:0];
      REG_DEBOUNCE_MS: cfg_mirror.debounce_ms = data[9:0];
      default: ;
    endcase
  endfunction

  // one sample or poll word in, one result word out, state updated in place
  function automatic result_t map_button_word(input logic op, input logic lvl,
                                              input logic [31:0] now);
    result_t    out;
    logic [4:0] sel;
    logic [31:0] gap;
    out = '0;
    gap = now - btn.last_sample_time;
    if (op == OP_SAMPLE) begin
      // debounce: the gap must strictly exceed the window, wrapping mod 2^32
      if (gap > {22'd0, cfg_mirror.debounce_ms} && lvl != btn.accepted_level) begin
        btn.accepted_level = lvl;
        if (cfg_mirror.output_mode == MODE_DIRECT) begin
          btn.virtual_value  = {3'd0, lvl} + 4'd1;
          btn.pending_change = 1'b1;
        end else begin
          sel = {1'b0, btn.virtual_value};
          if (cfg_mirror.input_kind == KIND_PUSH) begin
            // push button counts presses, releases add nothing to the value
            if (lvl) begin
              sel = sel + 5'd1;
              btn.pending_change = 1'b1;
            end
          end else begin
            if (cfg_mirror.select_max == TOGGLE_PAIR_MAX) begin
              sel = {4'd0, lvl} + 5'd1;
            end else begin
              sel = sel + 5'd1;
            end
            btn.pending_change = 1'b1;
          end
          // wrap past the maximum, a zero maximum always lands on one
          if (sel > {1'b0, cfg_mirror.select_max}) begin
            sel = 5'd1;
          end
          btn.virtual_value = sel[3:0];
        end
        // a stale pending flag also re-arms the one-shot
        if (btn.pending_change && cfg_mirror.span_mode == SPAN_ONESHOT) begin
          btn.release_deadline = now + {16'd0, cfg_mirror.oneshot_ms};
          btn.release_armed    = 1'b1;
        end
      end
      btn.last_sample_time = now;
    end else if (btn.pending_change) begin
      if (btn.last_reported != {1'b0, btn.virtual_value}) begin
        out.event_valid   = 1'b1;
        out.event_value   = btn.virtual_value;
        btn.last_reported = {1'b0, btn.virtual_value};
      end
      btn.pending_change = 1'b0;
    end else if (btn.release_armed && cfg_mirror.span_mode == SPAN_ONESHOT &&
                 btn.release_deadline < now) begin
      // plain unsigned compare, no wrap handling on the deadline
      if (btn.last_reported != 5'd0) begin
        out.event_valid   = 1'b1;
        out.event_value   = 4'd0;
        btn.last_reported = 5'd0;
      end else begin
        btn.last_reported = NONE_REPORTED;
      end
      btn.release_armed = 1'b0;
    end
    out.current_value = btn.virtual_value;
    return out;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && result_valid && !result_stall) begin
      got = '{event_valid, event_value, current_value};
      if (button_out_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing expected: ev %0b val %0d cur %0d",
                                  got.event_valid, got.event_value, got.current_value));
      end else begin
        want = button_out_q.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf(
            "word %0d: expected ev %0b val %0d cur %0d, got ev %0b val %0d cur %0d",
            words_checked, want.event_valid, want.event_value, want.current_value,
            got.event_valid, got.event_value, got.current_value));
        end
      end
      words_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall, or a long hold-off when one is requested
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, button_out_q.size());
      $display("virtual_button_mapper_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one word, with random idle cycles ahead of it; predict on acceptance
  task automatic send_word(input logic op, input logic lvl, input logic [31:0] now);
    while ($urandom_range(99) < gap_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    operation    <= op;
    level        <= lvl;
    now_ms       <= now;
    @(posedge clk);
    while (sample_stall) begin
      offer_stalls++;
      @(posedge clk);
    end
    button_out_q.push_back(map_button_word(op, lvl, now));
    words_sent++;
  endtask

  // stop offering and let every predicted word come back, then settle
  task automatic wait_drained;
    sample_valid <= 1'b0;
    while (button_out_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write; bits above the register width are filled with noise
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value, input int bits);
    logic [31:0] keep;
    logic [31:0] raw;
    logic [15:0] data;
    keep = (32'd1 << bits) - 32'd1;
    raw  = ($urandom & ~keep) | ({16'd0, value} & keep);
    data = raw[15:0];
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    apply_reg_write(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  // random register setting, extremes weighted in; sometimes keep live state
  task automatic randomize_config;
    logic [15:0] sel_max;
    logic [15:0] oneshot;
    logic [15:0] debounce;
    case ($urandom_range(9))
      0:       sel_max = 16'd0;
      1:       sel_max = 16'd15;
      2:       sel_max = 16'd1;
      3:       sel_max = {12'd0, TOGGLE_PAIR_MAX};
      default: sel_max = 16'($urandom_range(1, 15));
    endcase
    case ($urandom_range(9))
      0:       oneshot = 16'd0;
      1:       oneshot = 16'hFFFF;
      default: oneshot = 16'($urandom_range(0, 300));
    endcase
    case ($urandom_range(9))
      0:       debounce = 16'd0;
      1:       debounce = 16'd1023;
      default: debounce = 16'($urandom_range(0, 60));
    endcase
    if ($urandom_range(3) != 0) begin
      write_reg(REG_INPUT_KIND, 16'($urandom_range(1)), 1);
      write_reg(REG_OUTPUT_MODE,
                16'(($urandom_range(9) < 7) ? MODE_SELECT : MODE_DIRECT), 1);
      write_reg(REG_SPAN_MODE, 16'($urandom_range(1)), 1);
    end
    write_reg(REG_SELECT_MAX, sel_max, 4);
    write_reg(REG_ONESHOT_MS, oneshot, 16);
    write_reg(REG_DEBOUNCE_MS, debounce, 10);
    write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 16'($urandom), 16);
  endtask

  // mostly plausible button activity timed against the debounce and one-shot
  // windows, with some fully random words and jumps to the edge of time wrap
  task automatic send_random_word;
    int          pick;
    int          r;
    logic [31:0] step;
    logic        lvl;
    pick = $urandom_range(99);
    r    = $urandom_range(99);
    if (pick < 5) begin
      ms_cursor = $urandom;
      send_word(1'($urandom_range(1)), 1'($urandom_range(1)), ms_cursor);
    end else if (pick < 9) begin
      ms_cursor = 32'hFFFF_FFFF - $urandom_range(0, 400);
      lvl = ~last_lvl;
      send_word(OP_SAMPLE, lvl, ms_cursor);
      last_lvl = lvl;
    end else if (pick < 54) begin
      if (r < 15) begin
        step = $urandom_range(0, cfg_mirror.debounce_ms);   // bounce
      end else if (r < 22) begin
        step = {22'd0, cfg_mirror.debounce_ms};             // on the window
      end else if (r < 28) begin
        step = {22'd0, cfg_mirror.debounce_ms} + 32'd1;     // just past it
      end else begin
        step = {22'd0, cfg_mirror.debounce_ms} + 32'd1 + $urandom_range(0, 80);
      end
      lvl = ($urandom_range(99) < 75) ? ~last_lvl : 1'($urandom_range(1));
      ms_cursor = ms_cursor + step;
      send_word(OP_SAMPLE, lvl, ms_cursor);
      last_lvl = lvl;
    end else begin
      if (r < 55) begin
        step = $urandom_range(0, 40);
      end else if (r < 80) begin
        step = {16'd0, cfg_mirror.oneshot_ms} + $urandom_range(0, 2);  // near deadline
      end else begin
        step = $urandom_range(0, 2 * cfg_mirror.oneshot_ms + 2);
      end
      ms_cursor = ms_cursor + step;
      send_word(OP_POLL, 1'($urandom_range(1)), ms_cursor);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // defaults after reset: push button, direct mapping, hold, debounce 20
  task automatic test_reset_defaults;
    gap_pct   = 0;
    stall_pct <= 0;
    send_word(OP_SAMPLE, 1'b1, 32'd20);   // gap equals debounce, rejected
    send_word(OP_POLL,   1'b0, 32'd21);   // nothing to report
    send_word(OP_SAMPLE, 1'b1, 32'd41);   // press taken, value 2
    send_word(OP_POLL,   1'b1, 32'd42);
    send_word(OP_SAMPLE, 1'b0, 32'd63);   // release, value 1
    send_word(OP_POLL,   1'b0, 32'd64);
    send_word(OP_SAMPLE, 1'b1, 32'd85);   // press and release between polls
    send_word(OP_SAMPLE, 1'b0, 32'd106);
    send_word(OP_POLL,   1'b0, 32'd107);  // same value as last report, no event
  endtask

  // select counting: zero maximum, toggle pair mode, wrap past a maximum
  task automatic test_select_counting;
    wait_drained;
    write_reg(REG_OUTPUT_MODE, 16'(MODE_SELECT), 1);
    write_reg(REG_INPUT_KIND, 16'(KIND_PUSH), 1);
    write_reg(REG_SPAN_MODE, 16'(SPAN_HOLD), 1);
    write_reg(REG_SELECT_MAX, 16'd0, 4);
    write_reg(REG_DEBOUNCE_MS, 16'd0, 10);
    send_word(OP_SAMPLE, 1'b1, 32'd0);    // zero gap never beats zero debounce
    send_word(OP_SAMPLE, 1'b1, 32'd1);    // any select update gives 1
    send_word(OP_POLL,   1'b0, 32'd1);
    wait_drained;
    write_reg(REG_INPUT_KIND, 16'(KIND_TOGGLE), 1);
    write_reg(REG_SELECT_MAX, {12'd0, TOGGLE_PAIR_MAX}, 4);
    write_reg(REG_DEBOUNCE_MS, 16'd1023, 10);
    send_word(OP_SAMPLE, 1'b1, 32'd1023); // widest window, rejected on the edge
    send_word(OP_SAMPLE, 1'b1, 32'd2047); // toggle follows the level, value 2
    send_word(OP_POLL,   1'b1, 32'd2048);
    wait_drained;
    write_reg(REG_SELECT_MAX, 16'd3, 4);  // state kept across this write
    send_word(OP_SAMPLE, 1'b0, 32'd3071); // counts up to 3
    send_word(OP_SAMPLE, 1'b1, 32'd4095); // past 3, wraps to 1
    send_word(OP_POLL,   1'b0, 32'd4096);
  endtask

  // one-shot release: zero delay boundary, widest delay wrapping past 2^32
  task automatic test_oneshot_release;
    wait_drained;
    write_reg(REG_OUTPUT_MODE, 16'(MODE_DIRECT), 1);
    write_reg(REG_SPAN_MODE, 16'(SPAN_ONESHOT), 1);
    write_reg(REG_ONESHOT_MS, 16'd0, 16);
    write_reg(REG_DEBOUNCE_MS, 16'd20, 10);
    send_word(OP_SAMPLE, 1'b1, 32'd100);  // armed with deadline 100
    send_word(OP_POLL,   1'b0, 32'd100);  // pending value first
    send_word(OP_POLL,   1'b0, 32'd100);  // deadline not yet below now
    send_word(OP_POLL,   1'b0, 32'd101);  // released to 0, value kept
    wait_drained;
    write_reg(REG_ONESHOT_MS, 16'hFFFF, 16);
    send_word(OP_SAMPLE, 1'b0, 32'hFFFF_FFF0);  // deadline wraps to a small number
    send_word(OP_POLL,   1'b1, 32'hFFFF_FFFF);
    send_word(OP_POLL,   1'b1, 32'hFFFF_FFFF);  // released at once
  endtask

  // receiver holds off long enough to back the block up, then mixed idling on both sides
  task automatic test_backpressure;
    wait_drained;
    randomize_config;
    gap_pct   = 0;
    stall_pct <= 0;
    hold_req  <= hold_req + 1;
    repeat (40) send_random_word;
    wait_drained;
    gap_pct   = 26;
    stall_pct <= 26;
    repeat (20) send_random_word;
  endtask

  task automatic test_random_traffic(input int n, input int gap, input int stall);
    wait_drained;
    randomize_config;
    gap_pct   = gap;
    stall_pct <= stall;
    repeat (n) send_random_word;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    cfg_mirror = '{KIND_PUSH, MODE_DIRECT, SPAN_HOLD, SELECT_MAX_RST,
                   ONESHOT_MS_RST, DEBOUNCE_MS_RST};
    btn = STATE_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults;
    test_select_counting;
    test_oneshot_release;
    test_backpressure;
    // idling phases: none, sender only, receiver only, both; twice over
    repeat (2) begin
      test_random_traffic(120, 0, 0);
      test_random_traffic(120, 46, 0);
      test_random_traffic(120, 0, 46);
      test_random_traffic(120, 26, 26);
    end
    wait_drained;

    $display("%0d words sent, %0d results checked, %0d register writes",
             words_sent, words_checked, reg_writes);
    $display("samples and polls across direct, select and one-shot modes; %0d stalled offers",
             offer_stalls);
    if (mismatches == 0 && button_out_q.size() == 0) begin
      $display("virtual_button_mapper_core: match");
    end else begin
      $display("virtual_button_mapper_core: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
sv/vbm_pkg.sv
sv/vbm_cfg_regs.sv
sv/vbm_step.sv
sv/virtual_button_mapper_core.sv
tb/tb_top.sv
